/* src/stbs_pkg.sv */
`timescale 1ns / 1ps
package stbs_pkg;

   localparam int DEPTH  = 1024;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int VAL_W  = 32;
   localparam int POS_W  = 11;
   localparam int KIND_W = 2;

   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOWER  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UPPER  = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             dropped;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic append;
      logic start;
      logic step;
      logic drop;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero;
      logic full;
      logic search_done;
      logic out_free;
   } status_type;

endpackage

/* src/sorted_table_bound_search_unit.sv */
`timescale 1ns / 1ps
// Sorted table with lower-bound and upper-bound search. A clear or an
// accepted append is taken without a stall and gives no result. A query runs a
// binary search with one probe per cycle of the table memory and then loads
// the result register; an append to a full table is dropped and gives a
// result with the dropped flag set.
// The unit works on one transaction at a time and stalls the request side
// until the current result has been handed to the output register, which
// holds it while the response side stalls.
module sorted_table_bound_search_unit
   import stbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   stbs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* src/stbs_ctrl.sv */
`timescale 1ns / 1ps
module stbs_ctrl
   import stbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [KIND_W-1:0] req_kind,
   output logic              req_stall,
   input  status_type        status,
   output cmd_type           cmd
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  KIND_APPEND: begin
                     if (status.full) begin
                        cmd.drop = 1'b1;
                        state_in = S_FINISH;
                     end else begin
                        cmd.append = 1'b1;
                     end
                  end
                  default: begin
                     cmd.start = 1'b1;
                     state_in  = status.count_zero ? S_FINISH : S_SEARCH;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            cmd.step = 1'b1;
            if (status.search_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/stbs_datapath.sv */
`timescale 1ns / 1ps
module stbs_datapath
   import stbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   logic [VAL_W-1:0] mem [DEPTH];

   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        lo_ff, hi_ff, mid_ff;
   logic [CNT_W-1:0]        lo_in, hi_in, mid_in;
   logic [CNT_W-1:0]        rd_addr;
   logic signed [VAL_W-1:0] target_ff, elem;
   logic [VAL_W-1:0]        rdata_ff;
   logic                    upper_ff, drop_ff, go_right;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;

   // rdata_ff always holds the entry at mid_ff while a search is running.
   assign elem     = rdata_ff;
   assign go_right = upper_ff ? !(target_ff < elem) : (elem < target_ff);

   always_comb begin
      if (go_right) begin
         lo_in = mid_ff + CNT_W'(1);
         hi_in = hi_ff;
      end else begin
         lo_in = lo_ff;
         hi_in = mid_ff;
      end
      mid_in  = lo_in + ((hi_in - lo_in) >> 1);
      rd_addr = cmd.start ? (count_ff >> 1) : mid_in;
   end

   assign status.count_zero  = (count_ff == '0);
   assign status.full        = (count_ff == CNT_W'(DEPTH));
   assign status.search_done = (lo_in >= hi_in);
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[count_ff[ADDR_W-1:0]] <= req_data.value;
      end
      rdata_ff <= mem[rd_addr[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         lo_ff     <= '0;
         hi_ff     <= count_ff;
         mid_ff    <= count_ff >> 1;
         target_ff <= req_data.value;
         upper_ff  <= (req_data.kind == KIND_UPPER);
         drop_ff   <= 1'b0;
      end else if (cmd.drop) begin
         lo_ff   <= count_ff;
         drop_ff <= 1'b1;
      end else if (cmd.step) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         mid_ff <= mid_in;
      end
      if (cmd.out_load) begin
         rsp_data_ff.position <= POS_W'(lo_ff);
         rsp_data_ff.dropped  <= drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            count_ff <= '0;
         end else if (cmd.append) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/sv/sorted_table_bound_search_unit_tb.sv */
`timescale 1ns / 1ps
module sorted_table_bound_search_unit_tb;
   import stbs_pkg::*;

   localparam longint WORD_MIN = -(longint'(1) << 31);
   localparam longint WORD_MAX = (longint'(1) << 31) - 1;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 50;

   typedef struct {
      req_type data;
      bit      after_drain;
      bit      quiet;
   } queued_request;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   queued_request pending_requests [$];
   rsp_type       expected_answers [$];

   // Shadow copy of the table, kept in step with accepted transactions.
   logic signed [VAL_W-1:0] shadow_rows [DEPTH];
   int row_count = 0;

   int  stim_count = 0;
   int  mismatch_count = 0;
   int  answers_seen = 0;
   bit  drain_next = 1'b0;
   bit  quiet_phase = 1'b0;
   bit  quiet_mode = 1'b0;
   bit  req_taken = 1'b0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   sorted_table_bound_search_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic longint clamp_word(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   // Half-open binary search over the occupied rows, exactly as the block probes.
   function automatic int bound_index(logic signed [VAL_W-1:0] target, bit upper);
      int lo;
      int hi;
      int mid;
      bit go_right;
      lo = 0;
      hi = row_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (upper) go_right = !(target < shadow_rows[mid]);
         else go_right = shadow_rows[mid] < target;
         if (go_right) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic void apply_request(req_type item);
      rsp_type answer;
      answer = '0;
      case (item.kind)
         KIND_CLEAR: begin
            row_count = 0;
         end
         KIND_APPEND: begin
            if (row_count >= DEPTH) begin
               answer.position = POS_W'(row_count);
               answer.dropped = 1'b1;
               expected_answers.push_back(answer);
            end else begin
               shadow_rows[row_count] = item.value;
               row_count++;
            end
         end
         default: begin
            answer.position = POS_W'(bound_index(item.value, item.kind == KIND_UPPER));
            expected_answers.push_back(answer);
         end
      endcase
   endfunction

   task automatic queue_request(input logic [KIND_W-1:0] kind, input longint value);
      queued_request entry;
      entry.data.kind = kind;
      entry.data.value = value[VAL_W-1:0];
      entry.after_drain = drain_next;
      entry.quiet = quiet_phase;
      drain_next = 1'b0;
      pending_requests.push_back(entry);
      stim_count++;
   endtask

   // Clear, load a run of rows (ascending or not), then query around them.
   task automatic queue_table_run(input int rows, input int queries, input bit ascending);
      longint row_values [$];
      longint cur;
      longint step_cap;
      longint target;
      int pick;
      queue_request(KIND_CLEAR, $urandom);
      case ($urandom_range(0, 3))
         0: cur = WORD_MIN;
         1: cur = WORD_MAX - $urandom_range(0, 64);
         default: cur = longint'(int'($urandom));
      endcase
      case ($urandom_range(0, 3))
         0: step_cap = 2;
         1: step_cap = 100;
         2: step_cap = longint'(1) << 20;
         default: step_cap = longint'(1) << 28;
      endcase
      repeat (rows) begin
         if (!ascending) cur = longint'(int'($urandom));
         row_values.push_back(cur);
         queue_request(KIND_APPEND, cur);
         cur = clamp_word(cur + longint'($urandom_range(0, int'(step_cap))));
      end
      repeat (queries) begin
         pick = $urandom_range(0, 7);
         if (row_values.size() == 0 || pick == 0) begin
            target = longint'(int'($urandom));
         end else if (pick == 1) begin
            target = $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
         end else begin
            target = row_values[$urandom_range(0, row_values.size() - 1)]
                     + longint'($urandom_range(0, 2)) - 1;
         end
         queue_request($urandom_range(0, 1) ? KIND_LOWER : KIND_UPPER, clamp_word(target));
      end
   endtask

   task automatic queue_random_block();
      int shape;
      shape = $urandom_range(0, 9);
      if ($urandom_range(0, 4) == 0) drain_next = 1'b1;
      if (shape <= 6) begin
         queue_table_run(($urandom_range(0, 7) == 0) ? $urandom_range(41, 200)
                                                      : $urandom_range(0, 40),
                         $urandom_range(1, 12), 1'b1);
      end else if (shape == 7) begin
         queue_table_run($urandom_range(0, 20), $urandom_range(1, 8), 1'b0);
      end else begin
         repeat ($urandom_range(1, 10))
            queue_request(KIND_W'($urandom_range(0, 3)), longint'(int'($urandom)));
      end
   endtask

   // Request driver: presents the next queued transaction once the previous one is taken.
   always @(negedge clock) begin
      queued_request entry;
      logic    next_valid;
      req_type next_data;
      next_valid = req_valid;
      next_data = req_data;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         next_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_requests.size() != 0 &&
                      !(pending_requests[0].after_drain && expected_answers.size() != 0)) begin
            entry = pending_requests.pop_front();
            next_valid = 1'b1;
            next_data = entry.data;
            if (entry.quiet) quiet_mode <= 1'b1;
            else if ($urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
         end
      end
      req_valid <= next_valid;
      req_data <= next_data;
   end

   // Response side: random stall bursts plus one long hold-off to back up the unit.
   always @(negedge clock) begin
      logic next_stall;
      if (reset) begin
         next_stall = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         next_stall = 1'b1;
      end else if (!hold_done && answers_seen >= 30) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         next_stall = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         next_stall = 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         next_stall = 1'b1;
      end else begin
         next_stall = 1'b0;
      end
      rsp_stall <= next_stall;
   end

   always @(posedge clock) begin
      rsp_type wanted;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) apply_request(req_data);
         if (rsp_valid && !rsp_stall) begin
            answers_seen++;
            if (expected_answers.size() == 0) begin
               $error("unexpected result transaction: position %0d, dropped %0d",
                      rsp_data.position, rsp_data.dropped);
               mismatch_count++;
            end else begin
               wanted = expected_answers.pop_front();
               if (rsp_data.position !== wanted.position) begin
                  $error("position: expected %0d, actual %0d",
                         wanted.position, rsp_data.position);
                  mismatch_count++;
               end
               if (rsp_data.dropped !== wanted.dropped) begin
                  $error("dropped: expected %0d, actual %0d",
                         wanted.dropped, rsp_data.dropped);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      longint seed_rows [8] = '{WORD_MIN, -5, -5, 0, 7, 7, 7, WORD_MAX};
      int stop_at;

      // Queries on an empty table, then a small table with duplicates and extremes.
      queue_request(KIND_LOWER, WORD_MIN);
      queue_request(KIND_UPPER, WORD_MAX);
      queue_request(KIND_CLEAR, 0);
      foreach (seed_rows[i]) queue_request(KIND_APPEND, seed_rows[i]);
      queue_request(KIND_LOWER, WORD_MIN);
      queue_request(KIND_LOWER, -5);
      queue_request(KIND_LOWER, 7);
      queue_request(KIND_LOWER, 8);
      queue_request(KIND_LOWER, WORD_MAX);
      queue_request(KIND_UPPER, WORD_MIN);
      queue_request(KIND_UPPER, -6);
      queue_request(KIND_UPPER, 7);
      queue_request(KIND_UPPER, WORD_MAX);
      // A smaller value after the maximum breaks the ordering.
      queue_request(KIND_APPEND, -100);
      queue_request(KIND_LOWER, 0);
      queue_request(KIND_UPPER, -100);
      queue_request(KIND_CLEAR, -1);
      queue_request(KIND_LOWER, 5);

      while (stim_count < 200) queue_random_block();

      // Fill the table completely; further appends must be refused.
      drain_next = 1'b1;
      queue_table_run(DEPTH, 8, 1'b1);
      queue_request(KIND_APPEND, WORD_MIN);
      queue_request(KIND_APPEND, WORD_MAX);
      queue_request(KIND_APPEND, longint'(int'($urandom)));
      queue_request(KIND_LOWER, longint'(int'($urandom)));
      queue_request(KIND_UPPER, WORD_MAX);

      stop_at = stim_count + 250;
      while (stim_count < stop_at) queue_random_block();

      quiet_phase = 1'b1;
      drain_next = 1'b1;
      queue_table_run(20, 15, 1'b1);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS sorted_table_bound_search_unit");
      end else begin
         $display("FAIL sorted_table_bound_search_unit");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("FAIL sorted_table_bound_search_unit");
      $finish;
   end

endmodule

/* files.f */
src/stbs_pkg.sv
src/stbs_ctrl.sv
src/stbs_datapath.sv
src/sorted_table_bound_search_unit.sv
tb/sv/sorted_table_bound_search_unit_tb.sv
